// ===== rtl/core/vda_pkg.sv =====
// Shared constants and types for the voxel dose accumulator.
`timescale 1ns / 1ps
`default_nettype none

package vda_pkg;

  // Store geometry
  localparam int MAX_VOXELS  = 4096;
  localparam int MAX_THREADS = 4;
  localparam int DEPTH       = MAX_VOXELS * MAX_THREADS;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLC_W       = $clog2(MAX_THREADS + 1);

  // Field widths
  localparam int COORD_W = 4;
  localparam int THR_W   = 2;
  localparam int DIN_W   = 16;
  localparam int SIZE_W  = 5;
  localparam int TCNT_W  = 3;
  localparam int IDX_W   = 15;
  localparam int DOSE_W  = 40;
  localparam int SQ_W    = 48;
  localparam int HIT_W   = 32;
  localparam int ENTRY_W = DOSE_W + SQ_W + HIT_W;

  // Opcodes
  localparam logic OP_SCORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_X_SIZE  = 2'd0;
  localparam logic [1:0] REG_Y_SIZE  = 2'd1;
  localparam logic [1:0] REG_Z_SIZE  = 2'd2;
  localparam logic [1:0] REG_THREADS = 2'd3;

  // Voxel lookup result
  typedef struct packed {
    logic             in_grid;
    logic [IDX_W-1:0] voxel;
  } vox_loc_t;

endpackage

`default_nettype wire

// ===== rtl/core/vda_index.sv =====
// Voxel index computation and grid bounds check.
`timescale 1ns / 1ps
`default_nettype none

module vda_index (
  input  wire logic [vda_pkg::SIZE_W-1:0]  x_size_i,
  input  wire logic [vda_pkg::SIZE_W-1:0]  y_size_i,
  input  wire logic [vda_pkg::SIZE_W-1:0]  z_size_i,
  input  wire logic [vda_pkg::COORD_W-1:0] vox_x_i,
  input  wire logic [vda_pkg::COORD_W-1:0] vox_y_i,
  input  wire logic [vda_pkg::COORD_W-1:0] vox_z_i,
  output vda_pkg::vox_loc_t                loc_o
);

  logic [2*vda_pkg::SIZE_W-1:0]                  plane;
  logic [vda_pkg::COORD_W+vda_pkg::SIZE_W-1:0]   row;
  logic [vda_pkg::COORD_W+2*vda_pkg::SIZE_W-1:0] slab;
  logic [vda_pkg::IDX_W-1:0]                     idx;
  logic                                          bounds_ok;

  // linear index x + y*xs + z*xs*ys
  always_comb begin
    plane     = x_size_i * y_size_i;
    row       = vox_y_i * x_size_i;
    slab      = vox_z_i * plane;
    idx       = vda_pkg::IDX_W'(vox_x_i) + vda_pkg::IDX_W'(row) + vda_pkg::IDX_W'(slab);
    bounds_ok = ({1'b0, vox_x_i} < x_size_i) && ({1'b0, vox_y_i} < y_size_i) &&
                ({1'b0, vox_z_i} < z_size_i);
    loc_o.in_grid = bounds_ok && (32'(idx) < 32'(vda_pkg::MAX_VOXELS));
    loc_o.voxel   = idx;
  end

endmodule

`default_nettype wire

// ===== rtl/core/voxel_dose_accumulator.sv =====
// Per-thread voxel dose histogram with merged readout.
//
// After reset the block clears all MAX_VOXELS*MAX_THREADS entries (16384)
// of its store, one entry per cycle; no beat is taken in that time, while
// register writes are. A score beat reads the entry of the single-port store
// when it is taken and then writes back the saturated sums. A read beat folds
// n = min(threads_used, MAX_THREADS) thread slices, since the store gives one
// thread slice per cycle. A beat outside the grid, or a read with threads_used
// of zero, reads no entry. One beat is worked on at a time; the result sits in
// an output register, so the next beat is taken while it waits. Score beats
// return zero totals, with status 0 inside the grid and 1 outside it.
`timescale 1ns / 1ps
`default_nettype none

module voxel_dose_accumulator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input beats
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // vox_x[3:0], vox_y[7:4], vox_z[11:8],
                                           // thread_id[13:12], dose_in[29:14], pad
  input  wire logic         s_axis_tuser,  // opcode
  // result beats
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [119:0]      m_axis_tdata,  // dose_total[39:0], square_total[87:40],
                                           // hit_total[119:88]
  output logic              m_axis_tuser,  // status
  // register port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCORE = 5'b00100,
    S_MERGE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  localparam int AW = vda_pkg::ADDR_W;
  localparam int DW = vda_pkg::DOSE_W;
  localparam int QW = vda_pkg::SQ_W;
  localparam int HW = vda_pkg::HIT_W;
  localparam int SW = vda_pkg::SLC_W;

  // configuration registers
  logic [vda_pkg::SIZE_W-1:0] x_size_q, y_size_q, z_size_q;
  logic [vda_pkg::TCNT_W-1:0] threads_q;
  logic                       cfg_wr;

  // control
  state_e         state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [SW-1:0]  slice_q, slice_d;
  logic           stat_q, stat_d;
  logic           m_valid_q, m_valid_d;

  // payload
  logic [vda_pkg::DIN_W-1:0]   dose_q, dose_d;
  logic [2*vda_pkg::DIN_W-1:0] sq_q, sq_d;
  logic [DW-1:0] acc_dose_q, acc_dose_d;
  logic [QW-1:0] acc_sq_q, acc_sq_d;
  logic [HW-1:0] acc_hit_q, acc_hit_d;
  logic          m_stat_q, m_stat_d;
  logic [DW-1:0] m_dose_q, m_dose_d;
  logic [QW-1:0] m_sq_q, m_sq_d;
  logic [HW-1:0] m_hit_q, m_hit_d;

  // store
  logic [vda_pkg::ENTRY_W-1:0] store_mem [vda_pkg::DEPTH];
  logic [vda_pkg::ENTRY_W-1:0] rdata_q, wdata;
  logic [AW-1:0]               mem_addr;
  logic                        mem_we, mem_re;

  // input fields
  logic [vda_pkg::COORD_W-1:0] in_x, in_y, in_z;
  logic [vda_pkg::THR_W-1:0]   in_tid;
  logic [vda_pkg::DIN_W-1:0]   in_dose;
  logic                        in_op;
  logic                        accept, out_free, last_slice, tid_ok;
  logic [SW-1:0]               n_slices;
  logic [AW-1:0]               score_addr, next_addr;
  vda_pkg::vox_loc_t           loc;

  // stored fields and sums
  logic [DW-1:0] rd_dose;
  logic [QW-1:0] rd_sq;
  logic [HW-1:0] rd_hit;
  logic [DW:0]   sc_dose_s, mg_dose_s;
  logic [QW:0]   sc_sq_s, mg_sq_s;
  logic [HW:0]   sc_hit_s, mg_hit_s;
  logic [DW-1:0] sc_dose, mg_dose;
  logic [QW-1:0] sc_sq, mg_sq;
  logic [HW-1:0] sc_hit, mg_hit;

  assign in_x    = s_axis_tdata[3:0];
  assign in_y    = s_axis_tdata[7:4];
  assign in_z    = s_axis_tdata[11:8];
  assign in_tid  = s_axis_tdata[13:12];
  assign in_dose = s_axis_tdata[29:14];
  assign in_op   = s_axis_tuser;

  // ---------------------------------------------------------------- register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_size_q  <= vda_pkg::SIZE_W'(16);
      y_size_q  <= vda_pkg::SIZE_W'(16);
      z_size_q  <= vda_pkg::SIZE_W'(16);
      threads_q <= vda_pkg::TCNT_W'(4);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        vda_pkg::REG_X_SIZE:  x_size_q  <= pwdata[vda_pkg::SIZE_W-1:0];
        vda_pkg::REG_Y_SIZE:  y_size_q  <= pwdata[vda_pkg::SIZE_W-1:0];
        vda_pkg::REG_Z_SIZE:  z_size_q  <= pwdata[vda_pkg::SIZE_W-1:0];
        vda_pkg::REG_THREADS: threads_q <= pwdata[vda_pkg::TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vda_pkg::REG_X_SIZE:  prdata = 32'(x_size_q);
      vda_pkg::REG_Y_SIZE:  prdata = 32'(y_size_q);
      vda_pkg::REG_Z_SIZE:  prdata = 32'(z_size_q);
      vda_pkg::REG_THREADS: prdata = 32'(threads_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- voxel lookup
  vda_index u_index (
    .x_size_i (x_size_q),
    .y_size_i (y_size_q),
    .z_size_i (z_size_q),
    .vox_x_i  (in_x),
    .vox_y_i  (in_y),
    .vox_z_i  (in_z),
    .loc_o    (loc)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    accept     = s_axis_tvalid && s_axis_tready;
    out_free   = !m_valid_q || m_axis_tready;
    tid_ok     = 32'(in_tid) < 32'(vda_pkg::MAX_THREADS);
    n_slices   = (32'(threads_q) > 32'(vda_pkg::MAX_THREADS)) ?
                 SW'(vda_pkg::MAX_THREADS) : SW'(threads_q);
    last_slice = (slice_q + SW'(1)) == n_slices;
    score_addr = AW'(AW'(in_tid) * AW'(vda_pkg::MAX_VOXELS)) + AW'(loc.voxel);
    next_addr  = addr_q + AW'(vda_pkg::MAX_VOXELS);

    rd_dose = rdata_q[DW-1:0];
    rd_sq   = rdata_q[DW+QW-1:DW];
    rd_hit  = rdata_q[DW+QW+HW-1:DW+QW];

    // write-back sums, saturating
    sc_dose_s = {1'b0, rd_dose} + (DW+1)'(dose_q);
    sc_sq_s   = {1'b0, rd_sq} + (QW+1)'(sq_q);
    sc_hit_s  = {1'b0, rd_hit} + (HW+1)'(1);
    sc_dose   = sc_dose_s[DW] ? '1 : sc_dose_s[DW-1:0];
    sc_sq     = sc_sq_s[QW]   ? '1 : sc_sq_s[QW-1:0];
    sc_hit    = sc_hit_s[HW]  ? '1 : sc_hit_s[HW-1:0];

    // merge sums, saturating
    mg_dose_s = {1'b0, acc_dose_q} + {1'b0, rd_dose};
    mg_sq_s   = {1'b0, acc_sq_q} + {1'b0, rd_sq};
    mg_hit_s  = {1'b0, acc_hit_q} + {1'b0, rd_hit};
    mg_dose   = mg_dose_s[DW] ? '1 : mg_dose_s[DW-1:0];
    mg_sq     = mg_sq_s[QW]   ? '1 : mg_sq_s[QW-1:0];
    mg_hit    = mg_hit_s[HW]  ? '1 : mg_hit_s[HW-1:0];
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    addr_d     = addr_q;
    slice_d    = slice_q;
    stat_d     = stat_q;
    dose_d     = dose_q;
    sq_d       = sq_q;
    acc_dose_d = acc_dose_q;
    acc_sq_d   = acc_sq_q;
    acc_hit_d  = acc_hit_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_stat_d   = m_stat_q;
    m_dose_d   = m_dose_q;
    m_sq_d     = m_sq_q;
    m_hit_d    = m_hit_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = addr_q;
    wdata      = {sc_hit, sc_sq, sc_dose};
    s_axis_tready = (state_q == S_IDLE);

    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        wdata    = '0;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(vda_pkg::DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          acc_dose_d = '0;
          acc_sq_d   = '0;
          acc_hit_d  = '0;
          slice_d    = '0;
          dose_d     = in_dose;
          sq_d       = in_dose * in_dose;
          stat_d     = vda_pkg::ST_OK;
          if (!loc.in_grid || (in_op == vda_pkg::OP_SCORE && !tid_ok)) begin
            stat_d  = vda_pkg::ST_OUTSIDE;
            state_d = S_EMIT;
          end else if (in_op == vda_pkg::OP_SCORE) begin
            mem_re   = 1'b1;
            mem_addr = score_addr;
            addr_d   = score_addr;
            state_d  = S_SCORE;
          end else if (n_slices == '0) begin
            state_d = S_EMIT;
          end else begin
            mem_re   = 1'b1;
            mem_addr = AW'(loc.voxel);
            addr_d   = AW'(loc.voxel);
            state_d  = S_MERGE;
          end
        end
      end

      // write back the entry; result is all zeros
      S_SCORE: begin
        mem_we   = 1'b1;
        mem_addr = addr_q;
        if (out_free) begin
          m_valid_d = 1'b1;
          m_stat_d  = vda_pkg::ST_OK;
          m_dose_d  = '0;
          m_sq_d    = '0;
          m_hit_d   = '0;
          state_d   = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end

      // fold one thread slice per cycle
      S_MERGE: begin
        if (last_slice) begin
          if (out_free) begin
            m_valid_d = 1'b1;
            m_stat_d  = vda_pkg::ST_OK;
            m_dose_d  = mg_dose;
            m_sq_d    = mg_sq;
            m_hit_d   = mg_hit;
            state_d   = S_IDLE;
          end else begin
            acc_dose_d = mg_dose;
            acc_sq_d   = mg_sq;
            acc_hit_d  = mg_hit;
            state_d    = S_EMIT;
          end
        end else begin
          acc_dose_d = mg_dose;
          acc_sq_d   = mg_sq;
          acc_hit_d  = mg_hit;
          slice_d    = slice_q + SW'(1);
          mem_re     = 1'b1;
          mem_addr   = next_addr;
          addr_d     = next_addr;
        end
      end

      // hand the held result to the output register
      S_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_stat_d  = stat_q;
          m_dose_d  = acc_dose_q;
          m_sq_d    = acc_sq_q;
          m_hit_d   = acc_hit_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      addr_q    <= '0;
      slice_q   <= '0;
      stat_q    <= vda_pkg::ST_OK;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      addr_q    <= addr_d;
      slice_q   <= slice_d;
      stat_q    <= stat_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dose_q     <= dose_d;
    sq_q       <= sq_d;
    acc_dose_q <= acc_dose_d;
    acc_sq_q   <= acc_sq_d;
    acc_hit_q  <= acc_hit_d;
    m_stat_q   <= m_stat_d;
    m_dose_q   <= m_dose_d;
    m_sq_q     <= m_sq_d;
    m_hit_q    <= m_hit_d;
  end

  // ---------------------------------------------------------------- store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------- outputs
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_stat_q;
  assign m_axis_tdata  = {m_hit_q, m_sq_q, m_dose_q};

endmodule

`default_nettype wire

// ===== verif/vda_result_check.sv =====
// Result checker for the voxel dose accumulator: mirrors the stores and compares result beats.
`timescale 1ns / 1ps

module vda_result_check (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // vox_x, vox_y, vox_z, thread_id, dose_in, pad
  input  wire logic         s_axis_tuser,   // opcode
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [119:0] m_axis_tdata,   // dose_total, square_total, hit_total
  input  wire logic         m_axis_tuser,   // status
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic         pready,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o,
  output int unsigned       scores_o,
  output int unsigned       reads_o,
  output int unsigned       outside_o,
  output int unsigned       capped_o,
  output int unsigned       reg_writes_o
);

  localparam int DW = vda_pkg::DOSE_W;
  localparam int QW = vda_pkg::SQ_W;
  localparam int HW = vda_pkg::HIT_W;

  localparam logic [63:0] DOSE_CAP = {{(64-DW){1'b0}}, {DW{1'b1}}};
  localparam logic [63:0] SQ_CAP   = {{(64-QW){1'b0}}, {QW{1'b1}}};
  localparam logic [63:0] HIT_CAP  = {{(64-HW){1'b0}}, {HW{1'b1}}};

  typedef struct packed {
    logic          status;
    logic [DW-1:0] dose;
    logic [QW-1:0] square;
    logic [HW-1:0] hits;
  } voxel_sum_t;

  // mirrored per-thread stores and register copies
  logic [DW-1:0] dose_acc   [vda_pkg::DEPTH];
  logic [QW-1:0] square_acc [vda_pkg::DEPTH];
  logic [HW-1:0] hit_acc    [vda_pkg::DEPTH];
  logic [vda_pkg::SIZE_W-1:0] x_cells, y_cells, z_cells;
  logic [vda_pkg::TCNT_W-1:0] slices_read;

  voxel_sum_t  sums_due[$];
  voxel_sum_t  due, seen;
  int unsigned fault_cnt, score_cnt, read_cnt, off_grid_cnt, ceiling_cnt, write_cnt;

  initial begin
    for (int e = 0; e < vda_pkg::DEPTH; e++) begin
      dose_acc[e]   = '0;
      square_acc[e] = '0;
      hit_acc[e]    = '0;
    end
  end

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] ceiling);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ceiling}) ? ceiling : s[63:0];
  endfunction

  // Deposit into or merge over the thread slices; returns the result the beat should give.
  function automatic voxel_sum_t apply_beat(input logic op,
                                            input logic [vda_pkg::COORD_W-1:0] x,
                                            input logic [vda_pkg::COORD_W-1:0] y,
                                            input logic [vda_pkg::COORD_W-1:0] z,
                                            input logic [vda_pkg::THR_W-1:0] tid,
                                            input logic [vda_pkg::DIN_W-1:0] dose);
    voxel_sum_t  r;
    int unsigned vox, ent, n;
    r = '0;
    r.status = vda_pkg::ST_OK;
    vox = int'(x) + int'(y) * int'(x_cells) + int'(z) * int'(x_cells) * int'(y_cells);
    if (x >= x_cells || y >= y_cells || z >= z_cells || vox >= vda_pkg::MAX_VOXELS) begin
      r.status = vda_pkg::ST_OUTSIDE;
    end else if (op == vda_pkg::OP_SCORE) begin
      if (int'(tid) >= vda_pkg::MAX_THREADS) begin
        r.status = vda_pkg::ST_OUTSIDE;
      end else begin
        ent = int'(tid) * vda_pkg::MAX_VOXELS + vox;
        dose_acc[ent]   = DW'(sat_sum(64'(dose_acc[ent]), 64'(dose), DOSE_CAP));
        square_acc[ent] = QW'(sat_sum(64'(square_acc[ent]), 64'(dose) * 64'(dose), SQ_CAP));
        hit_acc[ent]    = HW'(sat_sum(64'(hit_acc[ent]), 64'd1, HIT_CAP));
      end
    end else begin
      // slice count clamps to the store's thread count
      n = (int'(slices_read) > vda_pkg::MAX_THREADS) ? vda_pkg::MAX_THREADS
                                                     : int'(slices_read);
      for (int t = 0; t < n; t++) begin
        ent = t * vda_pkg::MAX_VOXELS + vox;
        r.dose   = DW'(sat_sum(64'(r.dose), 64'(dose_acc[ent]), DOSE_CAP));
        r.square = QW'(sat_sum(64'(r.square), 64'(square_acc[ent]), SQ_CAP));
        r.hits   = HW'(sat_sum(64'(r.hits), 64'(hit_acc[ent]), HIT_CAP));
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cells      = 5'd16;
      y_cells      = 5'd16;
      z_cells      = 5'd16;
      slices_read  = 3'd4;
      sums_due.delete();
      fault_cnt    = 0;
      score_cnt    = 0;
      read_cnt     = 0;
      off_grid_cnt = 0;
      ceiling_cnt  = 0;
      write_cnt    = 0;
    end else begin
      // result side first: a beat taken at this edge cannot be answered at it
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{status: m_axis_tuser, dose: m_axis_tdata[39:0],
                 square: m_axis_tdata[87:40], hits: m_axis_tdata[119:88]};
        if (sums_due.size() == 0) begin
          if (fault_cnt < 10)
            $display("%0t: result beat with none outstanding: status %0d dose %h square %h hits %h",
                     $realtime, seen.status, seen.dose, seen.square, seen.hits);
          fault_cnt++;
        end else begin
          due = sums_due.pop_front();
          if (seen !== due) begin
            if (fault_cnt < 10) begin
              $display("%0t: mismatch: exp status %0d dose %h square %h hits %h",
                       $realtime, due.status, due.dose, due.square, due.hits);
              $display("%0t:           got status %0d dose %h square %h hits %h",
                       $realtime, seen.status, seen.dose, seen.square, seen.hits);
            end
            fault_cnt++;
          end
        end
      end

      // input side
      if (s_axis_tvalid && s_axis_tready) begin
        due = apply_beat(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4],
                         s_axis_tdata[11:8], s_axis_tdata[13:12], s_axis_tdata[29:14]);
        sums_due = {sums_due, due};
        if (s_axis_tuser == vda_pkg::OP_READ) read_cnt++;
        else score_cnt++;
        if (due.status == vda_pkg::ST_OUTSIDE) off_grid_cnt++;
        if (64'(due.dose) == DOSE_CAP || 64'(due.square) == SQ_CAP || 64'(due.hits) == HIT_CAP)
          ceiling_cnt++;
      end

      // register writes
      if (psel && penable && pwrite && pready) begin
        write_cnt++;
        case (paddr[3:2])
          vda_pkg::REG_X_SIZE:  x_cells     = pwdata[vda_pkg::SIZE_W-1:0];
          vda_pkg::REG_Y_SIZE:  y_cells     = pwdata[vda_pkg::SIZE_W-1:0];
          vda_pkg::REG_Z_SIZE:  z_cells     = pwdata[vda_pkg::SIZE_W-1:0];
          vda_pkg::REG_THREADS: slices_read = pwdata[vda_pkg::TCNT_W-1:0];
          default: ;
        endcase
      end
    end

    mismatches_o  <= fault_cnt;
    outstanding_o <= sums_due.size();
    scores_o      <= score_cnt;
    reads_o       <= read_cnt;
    outside_o     <= off_grid_cnt;
    capped_o      <= ceiling_cnt;
    reg_writes_o  <= write_cnt;
  end

endmodule

// ===== verif/voxel_dose_accumulator_tb.sv =====
// Testbench top for the voxel dose accumulator: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module voxel_dose_accumulator_tb;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 20;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata  = '0;   // vox_x[3:0], vox_y[7:4], vox_z[11:8],
                                      // thread_id[13:12], dose_in[29:14], pad
  logic         s_axis_tuser  = 1'b0; // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;         // dose_total[39:0], square_total[87:40],
                                      // hit_total[119:88]
  logic         m_axis_tuser;         // status
  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [3:0]   paddr   = '0;
  logic [31:0]  pwdata  = '0;
  logic [31:0]  prdata;
  logic         pready;

  int unsigned mismatches, outstanding, n_scores, n_reads, n_outside, n_capped, n_writes;

  // idle knobs; hold_req toggles to ask the sink for one long hold-off
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned grid_x = 16, grid_y = 16, grid_z = 16;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  voxel_dose_accumulator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  vda_result_check dose_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .scores_o      (n_scores),
    .reads_o       (n_reads),
    .outside_o     (n_outside),
    .capped_o      (n_capped),
    .reg_writes_o  (n_writes)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // mostly legal sizes, sometimes zero or oversized
  function automatic int unsigned pick_size();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 31);
    return $urandom_range(1, 16);
  endfunction

  // coordinates lean toward a few hot voxels inside the grid so reads find deposits
  function automatic logic [3:0] pick_coord(input int unsigned size);
    int unsigned lim;
    lim = (size > 16) ? 16 : size;
    if (lim == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(0, (lim < 3) ? lim - 1 : 2));
    return 4'($urandom_range(0, lim - 1));
  endfunction

  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic configure(input int unsigned xs, input int unsigned ys,
                           input int unsigned zs, input int unsigned nt);
    reg_write(vda_pkg::REG_X_SIZE, xs);
    reg_write(vda_pkg::REG_Y_SIZE, ys);
    reg_write(vda_pkg::REG_Z_SIZE, zs);
    reg_write(vda_pkg::REG_THREADS, nt);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    grid_x = xs;
    grid_y = ys;
    grid_z = zs;
  endtask

  task automatic send_beat(input logic op, input logic [3:0] x, input logic [3:0] y,
                           input logic [3:0] z, input logic [1:0] tid,
                           input logic [15:0] dose);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, dose, tid, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_beats(input int unsigned count);
    logic        op;
    logic [1:0]  tid;
    logic [15:0] dose;
    int unsigned k, pick;
    for (k = 0; k < count; k++) begin
      op   = ($urandom_range(0, 99) < 35) ? vda_pkg::OP_READ : vda_pkg::OP_SCORE;
      pick = $urandom_range(0, 9);
      dose = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      tid  = 2'($urandom_range(0, 3));
      send_beat(op, pick_coord(grid_x), pick_coord(grid_y), pick_coord(grid_z), tid, dose);
    end
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    bit          hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        for (stall = 0; stall < LONG_HOLD; stall++) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("Cycle limit reached with %0d results outstanding.", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: corner voxels, dose extremes, zero dose, unwritten voxel
    tx_gap_pct = 30;
    rx_stall_pct <= 30;
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd0, 4'd0, 2'd0, 16'h0000);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd0, 4'd0, 2'd1, 16'hFFFF);
    send_beat(vda_pkg::OP_SCORE, 4'd15, 4'd15, 4'd15, 2'd3, 16'hFFFF);
    send_beat(vda_pkg::OP_SCORE, 4'd15, 4'd15, 4'd15, 2'd2, 16'h0001);
    send_beat(vda_pkg::OP_READ, 4'd0, 4'd0, 4'd0, 2'd3, 16'hFFFF);
    send_beat(vda_pkg::OP_READ, 4'd15, 4'd15, 4'd15, 2'd0, 16'h0000);
    send_beat(vda_pkg::OP_READ, 4'd7, 4'd8, 4'd9, 2'd0, 16'h0000);
    send_beat(vda_pkg::OP_SCORE, 4'd15, 4'd0, 4'd0, 2'd0, 16'hAAAA);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd15, 4'd0, 2'd1, 16'h5555);
    send_beat(vda_pkg::OP_READ, 4'd15, 4'd0, 4'd0, 2'd0, 16'h0000);
    send_beat(vda_pkg::OP_READ, 4'd0, 4'd15, 4'd0, 2'd0, 16'h0000);

    // small grid, one slice summed: each axis just outside, deposit in an unsummed slice
    drain();
    configure(4, 3, 2, 1);
    send_beat(vda_pkg::OP_SCORE, 4'd3, 4'd2, 4'd1, 2'd2, 16'd500);
    send_beat(vda_pkg::OP_SCORE, 4'd4, 4'd0, 4'd0, 2'd0, 16'd7);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd3, 4'd0, 2'd0, 16'd7);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd0, 4'd2, 2'd0, 16'd7);
    send_beat(vda_pkg::OP_READ, 4'd3, 4'd2, 4'd1, 2'd0, 16'd0);
    send_beat(vda_pkg::OP_READ, 4'd4, 4'd0, 4'd0, 2'd0, 16'd0);

    // oversized sizes: voxel index can pass the store size; thread count above the slices
    drain();
    configure(31, 31, 31, 7);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd0, 4'd4, 2'd0, 16'd100);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd0, 4'd5, 2'd1, 16'd100);
    send_beat(vda_pkg::OP_READ, 4'd0, 4'd0, 4'd5, 2'd0, 16'd0);
    send_beat(vda_pkg::OP_READ, 4'd0, 4'd0, 4'd4, 2'd0, 16'd0);
    send_beat(vda_pkg::OP_READ, 4'd15, 4'd15, 4'd15, 2'd0, 16'd0);

    // zero size, then zero threads summed
    drain();
    configure(0, 16, 16, 0);
    send_beat(vda_pkg::OP_SCORE, 4'd0, 4'd0, 4'd0, 2'd0, 16'd9);
    drain();
    configure(16, 16, 16, 0);
    send_beat(vda_pkg::OP_READ, 4'd0, 4'd0, 4'd0, 2'd0, 16'd0);

    // random phases over several geometries
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(16, 16, 16, 4);
        1: configure(1, 1, 1, 1);
        2: configure(2, 16, 3, 2);
        default: configure(pick_size(), pick_size(), pick_size(), $urandom_range(0, 7));
      endcase
      if (ph == 0) begin
        // receiver holds off while the sender keeps offering
        tx_gap_pct = 0;
        rx_stall_pct <= 0;
        random_beats(20);
        hold_req <= ~hold_req;
        random_beats(60);
      end else begin
        tx_gap_pct = 20 * $urandom_range(0, 2);
        rx_stall_pct <= 20 * $urandom_range(0, 2);
        random_beats(80);
      end
    end

    // full-grid readout after the random phases, then a short random tail
    drain();
    configure(16, 16, 16, 4);
    rx_stall_pct <= 20;
    tx_gap_pct = 20;
    send_beat(vda_pkg::OP_READ, 4'd5, 4'd6, 4'd7, 2'd0, 16'h0000);
    random_beats(40);

    // wind down
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d deposits and %0d readouts (%0d off the grid) over %0d register writes;",
             n_scores, n_reads, n_outside, n_writes);
    $display("%0d results reached a saturation ceiling; %0d mismatches.", n_capped, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
